FILE: rtl/jd_pkg.sv
package jd_pkg;

  localparam int unsigned ID_W = 16;
  localparam int unsigned TYPE_W = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned WORKERS_DEF = 4;

  localparam logic [TYPE_W-1:0] HIGH_TYPE_BITS = 16'hFF00;
  localparam logic [TYPE_W-1:0] NO_PRIORITY = 16'h0000;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_DONE = 3'd1;
  localparam logic [2:0] CMD_DISPATCH = 3'd2;
  localparam logic [2:0] CMD_TYPE_Q = 3'd3;
  localparam logic [2:0] CMD_ID_Q = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_DISABLED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_NONE = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  localparam logic [2:0] REG_ACCEPT_ENABLE = 3'd0;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] jtype;
  } entry_t;

endpackage

FILE: rtl/jd_queue.sv
module jd_queue #(
  parameter int unsigned QUEUE_DEPTH = jd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned AW = $clog2(QUEUE_DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  jd_pkg::entry_t  wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output jd_pkg::entry_t  rdata_o
);
  import jd_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/job_dispatcher.sv
// Add, worker done and unknown commands: result in the cycle after start, busy stays low.
// Queries: scan the queued entries and stop early on a match; busy slots are checked too.
// Dispatch: per idle slot, scan for a match if a priority mask is set, fetch the pick,
// then shift the entries above it down; the registered queue read sets these steps.
// Results are strobes that the receiver cannot stall. Reset empties the queue,
// idles all slots, clears the priority mask and sets accept_enable.
module job_dispatcher #(
  parameter int unsigned QUEUE_DEPTH = jd_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned WORKERS = jd_pkg::WORKERS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                cmd_i,
  input  logic [jd_pkg::TYPE_W-1:0] type_bits_i,
  input  logic [jd_pkg::ID_W-1:0]   query_id_i,
  input  logic [1:0]                worker_sel_i,
  output logic                      res_valid_o,
  output logic [2:0]                status_o,
  output logic [jd_pkg::ID_W-1:0]   out_id_o,
  output logic [jd_pkg::TYPE_W-1:0] out_type_o,
  output logic [1:0]                out_worker_o,
  output logic                      found_o,
  output logic                      last_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import jd_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned WW = (WORKERS > 1) ? $clog2(WORKERS) : 1;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_WORKER  = 9'b000000010,
    S_SCAN_A  = 9'b000000100,
    S_SCAN_D  = 9'b000001000,
    S_QDONE   = 9'b000010000,
    S_FETCH_A = 9'b000100000,
    S_FETCH_D = 9'b001000000,
    S_SHIFT_A = 9'b010000000,
    S_SHIFT_D = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic accept_q, accept_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] pick_q, pick_d;
  logic [WW:0] wc_q, wc_d;
  logic n_q, n_d;
  logic hit_q, hit_d;
  logic [2:0] cmd_q, cmd_d;
  logic [TYPE_W-1:0] tb_q, tb_d;
  logic [ID_W-1:0] qid_q, qid_d;
  logic [ID_W-1:0] next_q, next_d;
  logic [TYPE_W-1:0] mask_q, mask_d;
  logic [WORKERS-1:0] wbusy_q, wbusy_d;
  logic [ID_W-1:0] wid_q [WORKERS];
  logic [ID_W-1:0] wid_d [WORKERS];
  logic [TYPE_W-1:0] wtype_q [WORKERS];
  logic [TYPE_W-1:0] wtype_d [WORKERS];

  logic res_valid_d, found_d, last_d;
  logic [2:0] status_d;
  logic [ID_W-1:0] out_id_d;
  logic [TYPE_W-1:0] out_type_d;
  logic [1:0] out_worker_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rdata;

  logic [ID_W-1:0] nid;
  logic [WW-1:0] wsel, wcur;
  logic scan_m, scan_end, worker_hit, idle_above, more_shift;

  jd_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .AW(AW)) u_queue (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy = (state_q != S_IDLE);
  assign pready = 1'b1;
  assign prdata = {31'b0, accept_q};

  assign nid = ((next_q + 1'b1) == '0) ? ID_W'(1) : (next_q + 1'b1);
  assign wsel = WW'(worker_sel_i);
  assign wcur = wc_q[WW-1:0];

  always_comb begin
    case (cmd_q)
      CMD_DISPATCH: scan_m = |(rdata.jtype & mask_q);
      CMD_TYPE_Q:   scan_m = |(rdata.jtype & tb_q);
      default:      scan_m = (rdata.id == qid_q);
    endcase
  end

  assign scan_end = (({1'b0, idx_q} + 1'b1) >= count_q);
  assign more_shift = (({1'b0, idx_q} + 1'b1) < count_q);

  always_comb begin
    worker_hit = 1'b0;
    idle_above = 1'b0;
    for (int k = 0; k < WORKERS; k++) begin
      if (wbusy_q[k]) begin
        if (cmd_q == CMD_TYPE_Q && |(wtype_q[k] & tb_q)) begin
          worker_hit = 1'b1;
        end
        if (cmd_q == CMD_ID_Q && wid_q[k] == qid_q) begin
          worker_hit = 1'b1;
        end
      end else if ((WW+1)'(k) > wc_q) begin
        idle_above = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    accept_d = accept_q;
    count_d = count_q;
    idx_d = idx_q;
    pick_d = pick_q;
    wc_d = wc_q;
    n_d = n_q;
    hit_d = hit_q;
    cmd_d = cmd_q;
    tb_d = tb_q;
    qid_d = qid_q;
    next_d = next_q;
    mask_d = mask_q;
    wbusy_d = wbusy_q;
    wid_d = wid_q;
    wtype_d = wtype_q;
    res_valid_d = 1'b0;
    status_d = status_o;
    out_id_d = out_id_o;
    out_type_d = out_type_o;
    out_worker_d = out_worker_o;
    found_d = found_o;
    last_d = last_o;
    we = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = '{id: nid, jtype: type_bits_i};
    raddr = idx_q;

    if (psel && penable && pwrite && paddr == REG_ACCEPT_ENABLE) begin
      accept_d = pwdata[0];
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = cmd_i;
          tb_d = type_bits_i;
          qid_d = query_id_i;
          res_valid_d = 1'b1;
          status_d = ST_OK;
          out_id_d = '0;
          out_type_d = '0;
          out_worker_d = '0;
          found_d = 1'b0;
          last_d = 1'b1;
          case (cmd_i)
            CMD_ADD: begin
              next_d = nid;
              out_id_d = nid;
              if (!accept_q) begin
                status_d = ST_DISABLED;
              end else if (count_q >= CW'(QUEUE_DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                we = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            CMD_DONE: begin
              if (32'(worker_sel_i) < WORKERS) begin
                wbusy_d[wsel] = 1'b0;
                wid_d[wsel] = '0;
                wtype_d[wsel] = '0;
              end
            end
            CMD_DISPATCH: begin
              res_valid_d = 1'b0;
              wc_d = '0;
              n_d = 1'b0;
              state_d = S_WORKER;
            end
            CMD_TYPE_Q, CMD_ID_Q: begin
              if ((cmd_i == CMD_TYPE_Q && (type_bits_i & HIGH_TYPE_BITS) == '0
                   && type_bits_i == '0) || (cmd_i == CMD_ID_Q && query_id_i == '0)) begin
                status_d = ST_IGNORED;
              end else begin
                res_valid_d = 1'b0;
                hit_d = 1'b0;
                idx_d = '0;
                state_d = (count_q == '0) ? S_QDONE : S_SCAN_A;
              end
            end
            default: status_d = ST_IGNORED;
          endcase
        end
      end
      S_WORKER: begin
        if (wc_q == (WW+1)'(WORKERS) || count_q == '0) begin
          if (!n_q) begin
            res_valid_d = 1'b1;
            status_d = ST_NONE;
            out_id_d = '0;
            out_type_d = '0;
            out_worker_d = '0;
            found_d = 1'b0;
            last_d = 1'b1;
          end
          state_d = S_IDLE;
        end else if (wbusy_q[wcur]) begin
          wc_d = wc_q + 1'b1;
        end else if (mask_q != NO_PRIORITY) begin
          idx_d = '0;
          state_d = S_SCAN_A;
        end else begin
          pick_d = '0;
          state_d = S_FETCH_A;
        end
      end
      S_SCAN_A: begin
        state_d = S_SCAN_D;
      end
      S_SCAN_D: begin
        if (cmd_q == CMD_DISPATCH) begin
          if (scan_m || scan_end) begin
            pick_d = scan_m ? idx_q : '0;
            state_d = S_FETCH_A;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = S_SCAN_A;
          end
        end else if (scan_m || scan_end) begin
          hit_d = scan_m;
          state_d = S_QDONE;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_SCAN_A;
        end
      end
      S_QDONE: begin
        res_valid_d = 1'b1;
        status_d = ST_OK;
        out_id_d = '0;
        out_type_d = '0;
        out_worker_d = '0;
        found_d = hit_q || worker_hit;
        last_d = 1'b1;
        if (cmd_q == CMD_TYPE_Q) begin
          mask_d = (hit_q || worker_hit) ? tb_q : NO_PRIORITY;
        end
        state_d = S_IDLE;
      end
      S_FETCH_A: begin
        raddr = pick_q;
        state_d = S_FETCH_D;
      end
      S_FETCH_D: begin
        res_valid_d = 1'b1;
        status_d = ST_OK;
        out_id_d = rdata.id;
        out_type_d = rdata.jtype;
        out_worker_d = 2'(wcur);
        found_d = 1'b0;
        last_d = (count_q == CW'(1)) || !idle_above;
        wbusy_d[wcur] = 1'b1;
        wid_d[wcur] = rdata.id;
        wtype_d[wcur] = rdata.jtype;
        n_d = 1'b1;
        idx_d = pick_q;
        state_d = S_SHIFT_A;
      end
      S_SHIFT_A: begin
        raddr = AW'({1'b0, idx_q} + 1'b1);
        if (more_shift) begin
          state_d = S_SHIFT_D;
        end else begin
          count_d = count_q - 1'b1;
          wc_d = wc_q + 1'b1;
          state_d = S_WORKER;
        end
      end
      S_SHIFT_D: begin
        we = 1'b1;
        waddr = idx_q;
        wdata = rdata;
        idx_d = idx_q + 1'b1;
        state_d = S_SHIFT_A;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      accept_q <= 1'b1;
      count_q <= '0;
      next_q <= '0;
      mask_q <= NO_PRIORITY;
      wbusy_q <= '0;
      res_valid_o <= 1'b0;
      for (int k = 0; k < WORKERS; k++) begin
        wid_q[k] <= '0;
        wtype_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      accept_q <= accept_d;
      count_q <= count_d;
      next_q <= next_d;
      mask_q <= mask_d;
      wbusy_q <= wbusy_d;
      res_valid_o <= res_valid_d;
      wid_q <= wid_d;
      wtype_q <= wtype_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pick_q <= pick_d;
    wc_q <= wc_d;
    n_q <= n_d;
    hit_q <= hit_d;
    cmd_q <= cmd_d;
    tb_q <= tb_d;
    qid_q <= qid_d;
    status_o <= status_d;
    out_id_o <= out_id_d;
    out_type_o <= out_type_d;
    out_worker_o <= out_worker_d;
    found_o <= found_d;
    last_o <= last_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> busy)
    else $error("non-final beat while idle");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o == ST_NONE) |-> last_o)
    else $error("empty pass beat not final");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import jd_pkg::*;

  typedef struct {
    logic [2:0]        status;
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] jtype;
    logic [1:0]        worker;
    logic              found;
    logic              last;
  } result_t;

  class dispatch_scoreboard;
    logic [TYPE_W-1:0] q_type[QUEUE_DEPTH_DEF];
    logic [ID_W-1:0]   q_id[QUEUE_DEPTH_DEF];
    int unsigned       q_count;
    bit                slot_busy[WORKERS_DEF];
    logic [ID_W-1:0]   slot_id[WORKERS_DEF];
    logic [TYPE_W-1:0] slot_type[WORKERS_DEF];
    logic [ID_W-1:0]   last_id;
    logic [TYPE_W-1:0] prio_mask;
    bit                accept_en;
    result_t           pending[$];
    int                errors;
    int                n_checked;

    function new();
      q_count = 0;
      last_id = '0;
      prio_mask = NO_PRIORITY;
      accept_en = 1'b1;
      errors = 0;
      n_checked = 0;
      foreach (slot_busy[w]) begin
        slot_busy[w] = 1'b0;
        slot_id[w] = '0;
        slot_type[w] = '0;
      end
    endfunction

    function void push(logic [2:0] st, logic [ID_W-1:0] id, logic [TYPE_W-1:0] jt,
                       logic [1:0] wk, logic fnd, logic lst);
      result_t r;
      r.status = st;
      r.id = id;
      r.jtype = jt;
      r.worker = wk;
      r.found = fnd;
      r.last = lst;
      pending = {pending, r};
    endfunction

    function void note_command(logic [2:0] cmd, logic [TYPE_W-1:0] tb,
                               logic [ID_W-1:0] qid, logic [1:0] ws);
      logic [2:0] st;
      int unsigned pick;
      int n;
      bit hit;
      case (cmd)
        CMD_ADD: begin
          last_id = last_id + 1'b1;
          if (last_id == '0) last_id = 1;
          if (!accept_en) begin
            st = ST_DISABLED;
          end else if (q_count >= QUEUE_DEPTH_DEF) begin
            st = ST_FULL;
          end else begin
            q_type[q_count] = tb;
            q_id[q_count] = last_id;
            q_count++;
            st = ST_OK;
          end
          push(st, last_id, '0, '0, 1'b0, 1'b1);
        end
        CMD_DONE: begin
          slot_busy[ws] = 1'b0;
          slot_id[ws] = '0;
          slot_type[ws] = '0;
          push(ST_OK, '0, '0, '0, 1'b0, 1'b1);
        end
        CMD_DISPATCH: begin
          n = 0;
          for (int w = 0; w < WORKERS_DEF && q_count > 0; w++) begin
            if (slot_busy[w]) continue;
            pick = 0;
            if (prio_mask != NO_PRIORITY) begin
              for (int i = 0; i < q_count; i++) begin
                if ((q_type[i] & prio_mask) != '0) begin
                  pick = i;
                  break;
                end
              end
            end
            slot_busy[w] = 1'b1;
            slot_id[w] = q_id[pick];
            slot_type[w] = q_type[pick];
            push(ST_OK, q_id[pick], q_type[pick], w[1:0], 1'b0, 1'b0);
            n++;
            for (int i = pick; i + 1 < q_count; i++) begin
              q_type[i] = q_type[i+1];
              q_id[i] = q_id[i+1];
            end
            q_count--;
          end
          if (n == 0) push(ST_NONE, '0, '0, '0, 1'b0, 1'b1);
          else pending[pending.size()-1].last = 1'b1;
        end
        CMD_TYPE_Q: begin
          if ((tb & HIGH_TYPE_BITS) == '0 && tb == '0) begin
            push(ST_IGNORED, '0, '0, '0, 1'b0, 1'b1);
          end else begin
            hit = 1'b0;
            prio_mask = tb;
            for (int i = 0; i < q_count; i++) if ((q_type[i] & tb) != '0) hit = 1'b1;
            foreach (slot_busy[w]) if (slot_busy[w] && (slot_type[w] & tb) != '0) hit = 1'b1;
            if (!hit) prio_mask = NO_PRIORITY;
            push(ST_OK, '0, '0, '0, hit, 1'b1);
          end
        end
        CMD_ID_Q: begin
          if (qid == '0) begin
            push(ST_IGNORED, '0, '0, '0, 1'b0, 1'b1);
          end else begin
            hit = 1'b0;
            for (int i = 0; i < q_count; i++) if (q_id[i] == qid) hit = 1'b1;
            foreach (slot_busy[w]) if (slot_busy[w] && slot_id[w] == qid) hit = 1'b1;
            push(ST_OK, '0, '0, '0, hit, 1'b1);
          end
        end
        default: push(ST_IGNORED, '0, '0, '0, 1'b0, 1'b1);
      endcase
    endfunction

    function void check_result(result_t act);
      result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d id=%h", $time, act.status, act.id);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      n_checked++;
      if (act.status !== exp_r.status || act.id !== exp_r.id || act.jtype !== exp_r.jtype ||
          act.worker !== exp_r.worker || act.found !== exp_r.found ||
          act.last !== exp_r.last) begin
        $display("%0t: mismatch expected st=%0d id=%h type=%h wk=%0d found=%0b last=%0b",
                 $time, exp_r.status, exp_r.id, exp_r.jtype, exp_r.worker, exp_r.found,
                 exp_r.last);
        $display("%0t:          actual   st=%0d id=%h type=%h wk=%0d found=%0b last=%0b",
                 $time, act.status, act.id, act.jtype, act.worker, act.found, act.last);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [2:0]        cmd_i;
  logic [TYPE_W-1:0] type_bits_i;
  logic [ID_W-1:0]   query_id_i;
  logic [1:0]        worker_sel_i;
  logic              res_valid_o;
  logic [2:0]        status_o;
  logic [ID_W-1:0]   out_id_o;
  logic [TYPE_W-1:0] out_type_o;
  logic [1:0]        out_worker_o;
  logic              found_o;
  logic              last_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  dispatch_scoreboard sb;
  int idle_cycles;
  int burst_left;
  int n_sent;
  int n_cfg;

  job_dispatcher i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .cmd_i(cmd_i), .type_bits_i(type_bits_i), .query_id_i(query_id_i),
    .worker_sel_i(worker_sel_i), .res_valid_o(res_valid_o), .status_o(status_o),
    .out_id_o(out_id_o), .out_type_o(out_type_o), .out_worker_o(out_worker_o),
    .found_o(found_o), .last_o(last_o), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni && res_valid_o) begin
      r.status = status_o;
      r.id = out_id_o;
      r.jtype = out_type_o;
      r.worker = out_worker_o;
      r.found = found_o;
      r.last = last_o;
      sb.check_result(r);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || res_valid_o || (start && !busy) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 5000) begin
      $display("%0t: watchdog expired", $time);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(logic [2:0] cmd, logic [TYPE_W-1:0] tb, logic [ID_W-1:0] qid,
                      logic [1:0] ws);
    start <= 1'b1;
    cmd_i <= cmd;
    type_bits_i <= tb;
    query_id_i <= qid;
    worker_sel_i <= ws;
    do @(posedge clk_i); while (busy);
    sb.note_command(cmd, tb, qid, ws);
    n_sent++;
  endtask

  task automatic pause_sender();
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_accept(logic en);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_ACCEPT_ENABLE);
    pwdata <= {31'b0, en};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.accept_en = en;
    pwrite <= 1'b0;
    @(posedge clk_i);
    if (prdata[0] !== en || pready !== 1'b1) begin
      $display("%0t: register read expected %0b actual %0b", $time, en, prdata[0]);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    n_cfg++;
  endtask

  function automatic logic [TYPE_W-1:0] rand_type();
    case ($urandom_range(0, 3))
      0: return 16'(1) << $urandom_range(0, 15);
      1: return HIGH_TYPE_BITS & 16'($urandom);
      2: return ~HIGH_TYPE_BITS & 16'($urandom);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_item();
    int sel;
    logic [ID_W-1:0] qid;
    sel = $urandom_range(0, 99);
    pause_sender();
    if (sel < 38) begin
      send(CMD_ADD, rand_type(), 16'($urandom), 2'($urandom));
    end else if (sel < 58) begin
      send(CMD_DISPATCH, 16'($urandom), 16'($urandom), 2'($urandom));
    end else if (sel < 73) begin
      send(CMD_DONE, 16'($urandom), 16'($urandom), 2'($urandom));
    end else if (sel < 84) begin
      send(CMD_TYPE_Q, ($urandom_range(0, 9) == 0) ? 16'h0 : rand_type(),
           16'($urandom), 2'($urandom));
    end else if (sel < 96) begin
      qid = ($urandom_range(0, 2) != 0) ? sb.last_id - 16'($urandom_range(0, 20))
                                         : 16'($urandom);
      send(CMD_ID_Q, 16'($urandom), qid, 2'($urandom));
    end else begin
      send(3'($urandom_range(5, 7)), 16'($urandom), 16'($urandom), 2'($urandom));
    end
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    burst_left = 0;
    n_sent = 0;
    n_cfg = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = CMD_ADD;
    type_bits_i = '0;
    query_id_i = '0;
    worker_sel_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(CMD_DISPATCH, 16'h0, 16'h0, 2'd0);
    send(CMD_TYPE_Q, 16'hFFFF, 16'h0, 2'd0);
    send(CMD_ADD, 16'h0000, 16'hFFFF, 2'd3);
    send(CMD_ADD, 16'hFFFF, 16'h0, 2'd0);
    send(CMD_ADD, 16'h8000, 16'h0, 2'd0);
    send(CMD_ADD, 16'h0001, 16'h0, 2'd0);
    send(CMD_TYPE_Q, 16'h0000, 16'h0, 2'd0);
    send(CMD_TYPE_Q, 16'h0001, 16'h0, 2'd0);
    send(CMD_ID_Q, 16'h0, 16'h0000, 2'd0);
    send(CMD_ID_Q, 16'h0, 16'h0002, 2'd0);
    send(CMD_ID_Q, 16'h0, 16'hFFFF, 2'd0);
    send(CMD_DISPATCH, 16'h0, 16'h0, 2'd0);
    send(CMD_TYPE_Q, 16'h0100, 16'h0, 2'd0);
    send(CMD_DISPATCH, 16'h0, 16'h0, 2'd0);
    send(CMD_DONE, 16'h0, 16'h0, 2'd3);
    send(CMD_DONE, 16'h0, 16'h0, 2'd0);
    send(CMD_DONE, 16'h0, 16'h0, 2'd0);
    send(3'd5, 16'h0, 16'h0, 2'd0);
    send(3'd6, 16'h0, 16'h0, 2'd0);
    send(3'd7, 16'hFFFF, 16'hFFFF, 2'd3);
    wait_drained();

    write_accept(1'b0);
    send(CMD_ADD, 16'h1234, 16'h0, 2'd0);
    wait_drained();
    write_accept(1'b1);

    // Fill the queue past its depth so the full case is reached.
    repeat (QUEUE_DEPTH_DEF + 2) begin
      pause_sender();
      send(CMD_ADD, rand_type(), 16'($urandom), 2'($urandom));
    end
    repeat (30) random_item();
    wait_drained();

    write_accept(1'b0);
    repeat (10) random_item();
    wait_drained();
    write_accept(1'b1);
    repeat (20) random_item();
    send(CMD_ID_Q, 16'h0, 16'h0001, 2'd0);
    wait_drained();

    $display("Sent %0d commands over %0d register writes; %0d results checked.",
             n_sent, n_cfg, sb.n_checked);
    $display("Covered add, done, dispatch, queries, full queue and disabled accept.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
